>>> src/eisnr_pkg.sv
// Package for the Eisenstein norm representation block.
// Holds widths, step addresses, micro-op and condition codes and the control ROM.
// No dependencies.
`default_nettype none

package eisnr_pkg;

    localparam int IN_W     = 24;
    localparam int NORM_W   = 24;
    localparam int MAX_REPS = 64;
    localparam int COEF_W   = 12;
    localparam int D_W      = NORM_W + 2;
    localparam int S_W      = (D_W + 1) / 2;
    localparam int B_W      = S_W;
    localparam int CNT_W    = $clog2(MAX_REPS + 1);
    localparam int STEP_W   = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SQRT  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ROOT  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WALK  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_TEST  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_STORE = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CHECK = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ADV   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_END   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WRAP  = 4'd9;

    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_SQRT,
        UOP_ROOT,
        UOP_WALK,
        UOP_STORE,
        UOP_ADV,
        UOP_END
    } t_uop;

    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_BEAT,
        CND_SQRT_MORE,
        CND_WALK_LOOP,
        CND_MISS,
        CND_STALL,
        CND_CNT_MAX,
        CND_MORE,
        CND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop                op;
        t_cond               cond;
        logic [STEP_W-1:0]   target;
    } t_uword;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_IDLE:  w = '{op: UOP_LOAD,  cond: CND_NO_BEAT,   target: STEP_IDLE};
            STEP_SQRT:  w = '{op: UOP_SQRT,  cond: CND_SQRT_MORE, target: STEP_SQRT};
            STEP_ROOT:  w = '{op: UOP_ROOT,  cond: CND_NEVER,     target: STEP_IDLE};
            STEP_WALK:  w = '{op: UOP_WALK,  cond: CND_WALK_LOOP, target: STEP_WALK};
            STEP_TEST:  w = '{op: UOP_NONE,  cond: CND_MISS,      target: STEP_END};
            STEP_STORE: w = '{op: UOP_STORE, cond: CND_STALL,     target: STEP_STORE};
            STEP_CHECK: w = '{op: UOP_NONE,  cond: CND_CNT_MAX,   target: STEP_END};
            STEP_ADV:   w = '{op: UOP_ADV,   cond: CND_MORE,      target: STEP_WALK};
            STEP_END:   w = '{op: UOP_END,   cond: CND_OUT_BUSY,  target: STEP_END};
            STEP_WRAP:  w = '{op: UOP_NONE,  cond: CND_ALWAYS,    target: STEP_IDLE};
            default:    w = '{op: UOP_NONE,  cond: CND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/eisenstein_norm_representations.sv
// Top level: lists pairs (a,b), a,b >= 0, with a*a + a*b + b*b = N, rising b, last one marked.
// Microcoded sequencer over a small datapath; uses eisnr_pkg for widths and the control ROM.
// Sequence: load, bitwise square root of 4N, root squared, then a walk that raises b or lowers
// the root, with store, count check and advance for each pair found, then the closing beat.
// One norm at a time, taken only in the idle step; at most MAX_REPS pairs are listed per norm.
// Reset (synchronous, active low) returns the sequencer to idle with no result pending.
`default_nettype none

module eisenstein_norm_representations (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [eisnr_pkg::IN_W-1:0]    i_s_tdata,   // [23:0] norm_value
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [2*eisnr_pkg::COEF_W-1:0]     o_m_tdata,   // [11:0] coef_a, [23:12] coef_b
    output logic                               o_m_tuser,   // [0] rep_valid
    output logic                               o_m_tlast    // last_rep
);
    import eisnr_pkg::*;

    localparam logic [D_W-1:0] BIT_TOP = D_W'(1) << (2 * (S_W - 1));

    logic [STEP_W-1:0] r_step, n_step;
    logic [D_W-1:0]    r_n4, n_n4;
    logic [D_W-1:0]    r_d, n_d;
    logic [D_W-1:0]    r_sq, n_sq;
    logic [D_W-1:0]    r_root, n_root;
    logic [D_W-1:0]    r_bit, n_bit;
    logic [B_W-1:0]    r_b, n_b;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic [COEF_W-1:0] r_pa, n_pa;
    logic [COEF_W-1:0] r_pb, n_pb;
    logic              r_ovalid, n_ovalid;
    logic [COEF_W-1:0] r_oa, n_oa;
    logic [COEF_W-1:0] r_ob, n_ob;
    logic              r_orv, n_orv;
    logic              r_olast, n_olast;

    t_uword            uw;
    logic              in_beat;
    logic              out_free;
    logic              taken;
    logic [S_W-1:0]    s;
    logic              sq_gt_d;
    logic              hit;
    logic              more;
    logic              stall;
    logic              cnt_max;
    logic [B_W+2:0]    six_b3;
    logic [S_W-1:0]    diff;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [D_W:0]      sqrt_t;
    logic              sqrt_ge;
    logic [D_W-1:0]    n4_in;

    assign uw       = ucode(r_step);
    assign o_s_tready = (r_step == STEP_IDLE);
    assign in_beat  = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;

    assign s       = r_root[S_W-1:0];
    assign sq_gt_d = r_sq > r_d;
    assign hit     = (r_sq == r_d) && (s >= r_b) && (s[0] == r_b[0]);
    assign six_b3  = {1'b0, r_b, 2'b00} + {2'b00, r_b, 1'b0} + (B_W + 3)'(3);
    assign more    = r_d >= D_W'(six_b3);
    assign stall   = r_pend && !out_free;
    assign cnt_max = r_cnt == CNT_W'(MAX_REPS);
    assign diff    = s - r_b;
    assign coef_a  = COEF_W'(diff >> 1);
    assign coef_b  = COEF_W'(r_b);
    assign sqrt_t  = {1'b0, r_root} + {1'b0, r_bit};
    assign sqrt_ge = {1'b0, r_sq} >= sqrt_t;
    assign n4_in   = D_W'(NORM_W'(i_s_tdata)) << 2;

    always_comb begin
        case (uw.cond)
            CND_NEVER:     taken = 1'b0;
            CND_ALWAYS:    taken = 1'b1;
            CND_NO_BEAT:   taken = !in_beat;
            CND_SQRT_MORE: taken = r_bit != D_W'(1);
            CND_WALK_LOOP: taken = sq_gt_d || (!hit && more);
            CND_MISS:      taken = !hit;
            CND_STALL:     taken = stall;
            CND_CNT_MAX:   taken = cnt_max;
            CND_MORE:      taken = more;
            CND_OUT_BUSY:  taken = !out_free;
            default:       taken = 1'b1;
        endcase
        n_step = taken ? uw.target : r_step + STEP_W'(1);
    end

    always_comb begin
        n_n4     = r_n4;
        n_d      = r_d;
        n_sq     = r_sq;
        n_root   = r_root;
        n_bit    = r_bit;
        n_b      = r_b;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_ovalid = r_ovalid && !i_m_tready;
        n_oa     = r_oa;
        n_ob     = r_ob;
        n_orv    = r_orv;
        n_olast  = r_olast;
        case (uw.op)
            UOP_LOAD: begin
                if (in_beat) begin
                    n_n4   = n4_in;
                    n_d    = n4_in;
                    n_sq   = n4_in;
                    n_root = '0;
                    n_bit  = BIT_TOP;
                    n_b    = '0;
                    n_cnt  = '0;
                    n_pend = 1'b0;
                end
            end
            UOP_SQRT: begin
                if (sqrt_ge) begin
                    n_sq   = D_W'({1'b0, r_sq} - sqrt_t);
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
            end
            UOP_ROOT: begin
                n_sq = r_n4 - r_sq;
            end
            UOP_WALK: begin
                if (sq_gt_d) begin
                    n_sq   = r_sq - ((r_root << 1) - D_W'(1));
                    n_root = r_root - D_W'(1);
                end else if (!hit && more) begin
                    n_d = r_d - D_W'(six_b3);
                    n_b = r_b + B_W'(1);
                end
            end
            UOP_STORE: begin
                if (!stall) begin
                    if (r_pend) begin
                        n_ovalid = 1'b1;
                        n_oa     = r_pa;
                        n_ob     = r_pb;
                        n_orv    = 1'b1;
                        n_olast  = 1'b0;
                    end
                    n_pend = 1'b1;
                    n_pa   = coef_a;
                    n_pb   = coef_b;
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end
            UOP_ADV: begin
                if (more) begin
                    n_d = r_d - D_W'(six_b3);
                    n_b = r_b + B_W'(1);
                end
            end
            UOP_END: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oa     = r_pend ? r_pa : '0;
                    n_ob     = r_pend ? r_pb : '0;
                    n_orv    = r_pend;
                    n_olast  = 1'b1;
                    n_pend   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_IDLE;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n4    <= n_n4;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_b     <= n_b;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_oa    <= n_oa;
        r_ob    <= n_ob;
        r_orv   <= n_orv;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_ob, r_oa};
    assign o_m_tuser  = r_orv;
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire
